// File: rtl/hsvrgb_pkg.sv
// Shared constants, types and beat formats of the HSV to RGB converter.
package hsvrgb_pkg;

  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_W         = 15;
  localparam int CH_W          = 8;
  localparam int HUE_EXT_W     = 17;
  localparam int VS_W          = 2 * CH_W;
  localparam int CHN_W         = VS_W + 1;
  localparam int Q_SHIFT       = 9;
  localparam int QREM_W        = 10;
  localparam int N_STAGE       = 5;

  localparam logic [HUE_EXT_W-1:0] SEXTANT_SPAN = HUE_EXT_W'(60 << HUE_FRAC_BITS);
  localparam logic [HUE_EXT_W-1:0] HUE_LIMIT    = HUE_EXT_W'(360 << HUE_FRAC_BITS);

  // Span is 15 << (frac + 2), so the rounding divide is a shift and a divide by 15
  localparam int T_W         = $clog2((60 << HUE_FRAC_BITS) + 1);
  localparam int PROD_W      = CH_W + T_W;
  localparam int RAMP_SHIFT  = HUE_FRAC_BITS + 2;
  localparam int Y_W         = PROD_W - RAMP_SHIFT;
  localparam int RECIP_W     = 12;
  localparam int RECIP_SHIFT = 15;
  localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_W'(2185);

  localparam logic [CHN_W-1:0]  MAX_LEVEL  = CHN_W'(255);
  localparam logic [QREM_W-1:0] CHROMA_DIV = QREM_W'(510);
  localparam logic [CH_W-1:0]   WHITE      = CH_W'(8'hff);

  typedef enum logic [2:0] {
    SEXT_RY = 3'd0,
    SEXT_YG = 3'd1,
    SEXT_GC = 3'd2,
    SEXT_CB = 3'd3,
    SEXT_BM = 3'd4,
    SEXT_MR = 3'd5
  } sextant_t;

  typedef struct packed {
    logic [N_STAGE-1:0] load;
  } pipe_ctl_t;

  typedef struct packed {
    logic            oor;
    sextant_t        sext;
    logic [CH_W-1:0] chroma;
    logic [T_W-1:0]  t;
    logic [CH_W-1:0] val;
  } chroma_beat_t;

  typedef struct packed {
    logic            oor;
    sextant_t        sext;
    logic [CH_W-1:0] chroma;
    logic [CH_W-1:0] base;
    logic [CH_W-1:0] ramp;
  } ramp_beat_t;

endpackage

// File: rtl/hsvrgb_ctrl.sv
// Valid bits and per-stage load enables of the conversion pipeline.
module hsvrgb_ctrl
  import hsvrgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_stall,
  output logic      in_stall,
  output logic      out_valid,
  output pipe_ctl_t ctl
);

  logic [N_STAGE-1:0] valid_r;
  logic [N_STAGE-1:0] valid_nxt;
  logic [N_STAGE-1:0] load;

  // A stage loads when it is empty or its contents move on; bubbles collapse
  always_comb begin
    load[N_STAGE-1] = !valid_r[N_STAGE-1] || !out_stall;
    for (int i = N_STAGE - 2; i >= 0; i--) begin
      load[i] = !valid_r[i] || load[i+1];
    end
    valid_nxt[0] = load[0] ? in_valid : valid_r[0];
    for (int i = 1; i < N_STAGE; i++) begin
      valid_nxt[i] = load[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ctl.load  = load;
  assign in_stall  = !load[0];
  assign out_valid = valid_r[N_STAGE-1];

endmodule

// File: rtl/hsvrgb_chroma.sv
// Stages one and two: hue sextant split, V*S product and chroma rounding.
module hsvrgb_chroma
  import hsvrgb_pkg::*;
(
  input  logic             clk,
  input  pipe_ctl_t        ctl,
  input  logic [HUE_W-1:0] in_hue,
  input  logic [CH_W-1:0]  in_saturation,
  input  logic [CH_W-1:0]  in_brightness,
  output chroma_beat_t     beat
);

  logic [HUE_EXT_W-1:0] hue_ext;
  logic [HUE_EXT_W-1:0] base_sel;
  sextant_t             sext_nxt;

  logic                 s1_oor_r;
  sextant_t             s1_sext_r;
  logic [T_W-1:0]       s1_rem_r;
  logic [VS_W-1:0]      s1_vs_r;
  logic [CH_W-1:0]      s1_val_r;

  logic [CHN_W-1:0]     num;
  logic [CH_W-1:0]      q0;
  logic [QREM_W-1:0]    qrem;
  chroma_beat_t         beat_nxt;
  chroma_beat_t         beat_r;

  // Sextant by compare against the five boundaries
  always_comb begin
    hue_ext  = HUE_EXT_W'(in_hue);
    sext_nxt = SEXT_RY;
    base_sel = '0;
    for (int k = 1; k < 6; k++) begin
      if (hue_ext >= HUE_EXT_W'(k) * SEXTANT_SPAN) begin
        sext_nxt = sextant_t'(3'(k));
        base_sel = HUE_EXT_W'(k) * SEXTANT_SPAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_oor_r  <= hue_ext >= HUE_LIMIT;
      s1_sext_r <= sext_nxt;
      s1_rem_r  <= T_W'(hue_ext - base_sel);
      s1_vs_r   <= VS_W'(in_brightness) * VS_W'(in_saturation);
      s1_val_r  <= in_brightness;
    end
  end

  // Round(vs/255) = (2*vs+255)/510: divide by 512, then one correction step
  always_comb begin
    num  = CHN_W'({s1_vs_r, 1'b0}) + MAX_LEVEL;
    q0   = num[CHN_W-1:Q_SHIFT];
    qrem = QREM_W'(num[Q_SHIFT-1:0]) + QREM_W'({q0, 1'b0});
    beat_nxt.oor    = s1_oor_r;
    beat_nxt.sext   = s1_sext_r;
    beat_nxt.chroma = (qrem >= CHROMA_DIV) ? q0 + CH_W'(1) : q0;
    beat_nxt.t      = s1_sext_r[0] ? T_W'(SEXTANT_SPAN) - s1_rem_r : s1_rem_r;
    beat_nxt.val    = s1_val_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      beat_r <= beat_nxt;
    end
  end

  assign beat = beat_r;

endmodule

// File: rtl/hsvrgb_ramp.sv
// Stages three and four: C*t product, base level and rounded ramp value.
module hsvrgb_ramp
  import hsvrgb_pkg::*;
(
  input  logic         clk,
  input  pipe_ctl_t    ctl,
  input  chroma_beat_t in_beat,
  output ramp_beat_t   beat
);

  logic                s3_oor_r;
  sextant_t            s3_sext_r;
  logic [CH_W-1:0]     s3_chroma_r;
  logic [CH_W-1:0]     s3_base_r;
  logic [PROD_W-1:0]   s3_ct_r;

  logic [PROD_W-1:0]            rounded;
  logic [Y_W-1:0]               coarse;
  logic [Y_W+RECIP_W-1:0]       recip_prod;
  ramp_beat_t                   beat_nxt;
  ramp_beat_t                   beat_r;

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s3_oor_r    <= in_beat.oor;
      s3_sext_r   <= in_beat.sext;
      s3_chroma_r <= in_beat.chroma;
      s3_base_r   <= in_beat.val - in_beat.chroma;
      s3_ct_r     <= PROD_W'(in_beat.chroma) * PROD_W'(in_beat.t);
    end
  end

  // Add half a span, drop the power-of-two part, divide the rest by 15
  always_comb begin
    rounded    = s3_ct_r + PROD_W'(SEXTANT_SPAN >> 1);
    coarse     = rounded[PROD_W-1 -: Y_W];
    recip_prod = (Y_W + RECIP_W)'(coarse) * (Y_W + RECIP_W)'(RECIP_15);
    beat_nxt.oor    = s3_oor_r;
    beat_nxt.sext   = s3_sext_r;
    beat_nxt.chroma = s3_chroma_r;
    beat_nxt.base   = s3_base_r;
    beat_nxt.ramp   = recip_prod[RECIP_SHIFT +: CH_W];
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      beat_r <= beat_nxt;
    end
  end

  assign beat = beat_r;

endmodule

// File: rtl/hsv_to_rgb_convert_unit.sv
// Top level of the HSV to RGB converter: pipeline, channel placement, output register.
// Converts one HSV pixel per clock to 8-bit RGB. Hue is unsigned degrees with six
// fraction bits; saturation and brightness run 0..255 for 0.0..1.0. A pixel passes
// through five register stages on its way to out_valid (sextant split and V*S multiply,
// chroma rounding, C*t multiply, divide-by-span, channel placement), the first of
// which loads at the edge that accepts it.
// A new pixel is accepted every cycle unless the output is stalled and every stage is
// full; empty stages are filled even while the output waits. A hue of 360 degrees or
// more gives white with out_out_of_range set.
module hsv_to_rgb_convert_unit
  import hsvrgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [HUE_W-1:0] in_hue,
  input  logic [CH_W-1:0]  in_saturation,
  input  logic [CH_W-1:0]  in_brightness,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CH_W-1:0]  out_red,
  output logic [CH_W-1:0]  out_green,
  output logic [CH_W-1:0]  out_blue,
  output logic             out_out_of_range
);

  pipe_ctl_t       ctl;
  chroma_beat_t    chroma_beat;
  ramp_beat_t      ramp_beat;

  logic [CH_W-1:0] top;
  logic [CH_W-1:0] mid;
  logic [CH_W-1:0] red_nxt;
  logic [CH_W-1:0] green_nxt;
  logic [CH_W-1:0] blue_nxt;
  logic [CH_W-1:0] red_r;
  logic [CH_W-1:0] green_r;
  logic [CH_W-1:0] blue_r;
  logic            oor_r;

  hsvrgb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  hsvrgb_chroma u_chroma (
    .clk           (clk),
    .ctl           (ctl),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .beat          (chroma_beat)
  );

  hsvrgb_ramp u_ramp (
    .clk     (clk),
    .ctl     (ctl),
    .in_beat (chroma_beat),
    .beat    (ramp_beat)
  );

  always_comb begin
    top = ramp_beat.base + ramp_beat.chroma;
    mid = ramp_beat.base + ramp_beat.ramp;
    unique case (ramp_beat.sext)
      SEXT_RY: begin
        red_nxt = top;            green_nxt = mid;            blue_nxt = ramp_beat.base;
      end
      SEXT_YG: begin
        red_nxt = mid;            green_nxt = top;            blue_nxt = ramp_beat.base;
      end
      SEXT_GC: begin
        red_nxt = ramp_beat.base; green_nxt = top;            blue_nxt = mid;
      end
      SEXT_CB: begin
        red_nxt = ramp_beat.base; green_nxt = mid;            blue_nxt = top;
      end
      SEXT_BM: begin
        red_nxt = mid;            green_nxt = ramp_beat.base; blue_nxt = top;
      end
      default: begin
        red_nxt = top;            green_nxt = ramp_beat.base; blue_nxt = mid;
      end
    endcase
    // Force white when hue is past the last sextant
    if (ramp_beat.oor) begin
      red_nxt   = WHITE;
      green_nxt = WHITE;
      blue_nxt  = WHITE;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[N_STAGE-1]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      oor_r   <= ramp_beat.oor;
    end
  end

  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_out_of_range = oor_r;

endmodule

// File: rtl/hsvrgb_checker.sv
// Port-level assertions for the HSV to RGB converter and their bind.
module hsvrgb_checker
  import hsvrgb_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [HUE_W-1:0] in_hue,
  input logic [CH_W-1:0]  in_saturation,
  input logic [CH_W-1:0]  in_brightness,
  input logic             out_valid,
  input logic             out_stall,
  input logic [CH_W-1:0]  out_red,
  input logic [CH_W-1:0]  out_green,
  input logic [CH_W-1:0]  out_blue,
  input logic             out_out_of_range
);

  // Out-of-range beats are white
  a_oor_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |->
      out_red == WHITE && out_green == WHITE && out_blue == WHITE)
    else $error("out-of-range beat not white");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // Without output back-pressure the input never stalls
  a_no_stall_through: assert property (@(posedge clk)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue)
      && $stable(out_out_of_range))
    else $error("stalled result beat changed");

endmodule

bind hsv_to_rgb_convert_unit hsvrgb_checker u_hsvrgb_checker (.*);

// File: test/hsv_convert_checker.sv
// Watches both channels of the HSV to RGB converter, predicts each pixel and compares.
module hsv_convert_checker
  import hsvrgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [HUE_W-1:0] in_hue,
  input  logic [CH_W-1:0]  in_saturation,
  input  logic [CH_W-1:0]  in_brightness,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [CH_W-1:0]  out_red,
  input  logic [CH_W-1:0]  out_green,
  input  logic [CH_W-1:0]  out_blue,
  input  logic             out_out_of_range,
  output int               fail_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            oor;
  } rgb_pixel_t;

  rgb_pixel_t expected_pixels[$];

  function automatic rgb_pixel_t convert_hsv(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                                             logic [CH_W-1:0] val);
    rgb_pixel_t  px;
    int unsigned span, chroma, base, ramp, offs, slope_pos, top, mid;
    sextant_t    sext;
    span = 60 << HUE_FRAC_BITS;
    if (hue >= (360 << HUE_FRAC_BITS)) begin
      px.red   = WHITE;
      px.green = WHITE;
      px.blue  = WHITE;
      px.oor   = 1'b1;
      return px;
    end
    // chroma is V*S/255 rounded; the ramp is chroma scaled by the position in the sextant
    chroma    = (2 * val * sat + 255) / 510;
    base      = val - chroma;
    sext      = sextant_t'(3'(hue / span));
    offs      = hue % span;
    slope_pos = sext[0] ? span - offs : offs;
    ramp      = (2 * chroma * slope_pos + span) / (2 * span);
    top       = base + chroma;
    mid       = base + ramp;
    px.oor    = 1'b0;
    case (sext)
      SEXT_RY: begin
        px.red = CH_W'(top);  px.green = CH_W'(mid);  px.blue = CH_W'(base);
      end
      SEXT_YG: begin
        px.red = CH_W'(mid);  px.green = CH_W'(top);  px.blue = CH_W'(base);
      end
      SEXT_GC: begin
        px.red = CH_W'(base); px.green = CH_W'(top);  px.blue = CH_W'(mid);
      end
      SEXT_CB: begin
        px.red = CH_W'(base); px.green = CH_W'(mid);  px.blue = CH_W'(top);
      end
      SEXT_BM: begin
        px.red = CH_W'(mid);  px.green = CH_W'(base); px.blue = CH_W'(top);
      end
      default: begin
        px.red = CH_W'(top);  px.green = CH_W'(base); px.blue = CH_W'(mid);
      end
    endcase
    return px;
  endfunction

  task automatic report_field(string name, logic [CH_W-1:0] exp_v, logic [CH_W-1:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      // keep counting but stop flooding the log
      if (fail_count <= 100)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    rgb_pixel_t exp_px;
    if (!rst_n) begin
      fail_count = 0;
      expected_pixels.delete();
    end else begin
      // retire the result beat first, then enqueue the new pixel
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, got r=%0d g=%0d b=%0d oor=%0b",
                   $time, out_red, out_green, out_blue, out_out_of_range);
        end else begin
          exp_px = expected_pixels.pop_front();
          report_field("red", exp_px.red, out_red);
          report_field("green", exp_px.green, out_green);
          report_field("blue", exp_px.blue, out_blue);
          report_field("out_of_range", CH_W'(exp_px.oor), CH_W'(out_out_of_range));
        end
      end
      if (in_valid && !in_stall)
        expected_pixels.push_back(convert_hsv(in_hue, in_saturation, in_brightness));
    end
    pending_count = expected_pixels.size();
  end

endmodule

// File: test/testbench.sv
// Top of the HSV to RGB converter testbench: clock, reset, pixel stimulus and verdict.
module testbench;
  import hsvrgb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_PIXELS = 440;
  localparam int LONG_HOLD    = 60;
  localparam int DRAIN_CYCLES = 12;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_stall;
  logic [HUE_W-1:0] in_hue        = '0;
  logic [CH_W-1:0]  in_saturation = '0;
  logic [CH_W-1:0]  in_brightness = '0;
  logic             out_valid;
  logic             out_stall     = 1'b0;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;
  logic             out_out_of_range;
  int               fail_count;
  int               pending_count;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit long_hold_req = 1'b0;

  always #5 clk = ~clk;

  hsv_to_rgb_convert_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_hue           (in_hue),
    .in_saturation    (in_saturation),
    .in_brightness    (in_brightness),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_out_of_range (out_out_of_range)
  );

  hsv_convert_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_hue           (in_hue),
    .in_saturation    (in_saturation),
    .in_brightness    (in_brightness),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_out_of_range (out_out_of_range),
    .fail_count       (fail_count),
    .pending_count    (pending_count)
  );

  // Receiver: random stall, or a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_pixel(logic [HUE_W-1:0] h, logic [CH_W-1:0] s, logic [CH_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= h;
    in_saturation <= s;
    in_brightness <= v;
    // hold the beat until the block takes it
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  function automatic logic [CH_W-1:0] pick_level();
    logic [CH_W-1:0] corners[4] = '{8'd0, 8'd1, 8'd254, 8'd255};
    if ($urandom_range(99) < 15)
      return corners[$urandom_range(3)];
    return CH_W'($urandom_range(255));
  endfunction

  task automatic send_random_pixel();
    int               pick;
    logic [HUE_W-1:0] h;
    pick = $urandom_range(99);
    if (pick < 80)
      h = HUE_W'($urandom_range(HUE_LIMIT - 1, 0));
    else if (pick < 90)
      h = HUE_W'($urandom_range(32767, HUE_LIMIT));
    else
      // straddle a sextant edge, the top one being the range limit
      h = HUE_W'($urandom_range(6, 1) * SEXTANT_SPAN - 2 + $urandom_range(4));
    send_pixel(h, pick_level(), pick_level());
  endtask

  task automatic run_phase(int idle_pct, int hold_pct);
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    repeat (PHASE_PIXELS) send_random_pixel();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: sextant edges and middles, range limit, level extremes
    send_pixel(15'd0, 8'd255, 8'd255);
    send_pixel(15'd3839, 8'd255, 8'd255);
    send_pixel(15'd3840, 8'd255, 8'd255);
    send_pixel(15'd3841, 8'd255, 8'd255);
    send_pixel(15'd1920, 8'd128, 8'd200);
    send_pixel(15'd100, 8'd85, 8'd170);
    send_pixel(15'd7680, 8'd255, 8'd255);
    send_pixel(15'd9600, 8'd200, 8'd100);
    send_pixel(15'd11520, 8'd255, 8'd255);
    send_pixel(15'd13000, 8'd255, 8'd1);
    send_pixel(15'd15360, 8'd255, 8'd255);
    send_pixel(15'd17000, 8'd90, 8'd250);
    send_pixel(15'd19200, 8'd255, 8'd255);
    send_pixel(15'd21120, 8'd255, 8'd255);
    send_pixel(15'd21000, 8'd170, 8'd85);
    send_pixel(15'd23039, 8'd255, 8'd255);
    send_pixel(15'd23040, 8'd255, 8'd255);
    send_pixel(15'd32767, 8'd0, 8'd0);
    send_pixel(15'd16384, 8'd0, 8'd0);
    send_pixel(15'd5000, 8'd0, 8'd255);
    send_pixel(15'd5000, 8'd255, 8'd0);
    send_pixel(15'd0, 8'd0, 8'd0);
    send_pixel(15'd12345, 8'd1, 8'd1);
    send_pixel(15'd6000, 8'd1, 8'd255);

    run_phase(0, 0);
    // back-pressure: hold the output while the sender keeps offering beats
    send_idle_pct = 0;
    stall_pct     = 0;
    long_hold_req = 1'b1;
    repeat (40) send_random_pixel();
    run_phase(78, 0);
    run_phase(0, 78);
    run_phase(32, 32);
    in_valid <= 1'b0;

    stall_pct = 0;
    do @(negedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: hsv_to_rgb_convert_unit.f
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_ctrl.sv
rtl/hsvrgb_chroma.sv
rtl/hsvrgb_ramp.sv
rtl/hsv_to_rgb_convert_unit.sv
rtl/hsvrgb_checker.sv
test/hsv_convert_checker.sv
test/testbench.sv
